[rtl/segx_pkg.sv]
// shared constants and codes for the segment intersection block
`timescale 1ns / 1ps

package segx_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int STATUS_WIDTH    = 2;

    typedef enum logic [STATUS_WIDTH-1:0] {
        ST_NONE     = 2'd0,
        ST_CROSS    = 2'd1,
        ST_PARALLEL = 2'd2
    } status_t;

endpackage

[rtl/segx_div.sv]
// pipelined restoring divider, one quotient bit per stage, with overflow flag
`timescale 1ns / 1ps

module segx_div
    import segx_pkg::*;
#(
    parameter int QW = COORD_WIDTH_DEF + 1,
    parameter int NW = 3 * COORD_WIDTH_DEF + 5,
    parameter int DW = 2 * COORD_WIDTH_DEF + 4
) (
    input  logic          aclk,
    input  logic [QW:0]   en,
    input  logic [NW-1:0] n,
    input  logic [DW-1:0] d,
    output logic [QW-1:0] q,
    output logic          ovf
);

    localparam int HW = NW - QW;
    localparam int MW = (HW > DW) ? HW : DW;

    logic [NW-1:0] n_reg   [0:QW-1];
    logic [DW-1:0] d_reg   [0:QW-1];
    logic [DW-1:0] rem_reg [0:QW-1];
    logic [QW-1:0] q_reg   [0:QW];
    logic          ovf_reg [0:QW];

    logic [HW-1:0] hi;
    logic          ovf_next;

    assign hi       = n[NW-1:QW];
    assign ovf_next = MW'(hi) >= MW'(d);

    // quotient too large for the result width
    always_ff @(posedge aclk) begin
        if (en[0]) begin
            n_reg[0]   <= n;
            d_reg[0]   <= d;
            ovf_reg[0] <= ovf_next;
            rem_reg[0] <= ovf_next ? '0 : DW'(hi);
            q_reg[0]   <= '0;
        end
    end

    for (genvar k = 1; k <= QW; k++) begin : g_bit
        logic [DW:0]   t;
        logic          ge;

        assign t  = {rem_reg[k-1], n_reg[k-1][QW-k]};
        assign ge = t >= {1'b0, d_reg[k-1]};

        always_ff @(posedge aclk) begin
            if (en[k]) begin
                ovf_reg[k] <= ovf_reg[k-1];
                q_reg[k]   <= {q_reg[k-1][QW-2:0], ge};
            end
        end

        if (k < QW) begin : g_rem
            logic [DW-1:0] rem_next;

            assign rem_next = ge ? DW'(t - {1'b0, d_reg[k-1]}) : DW'(t);

            always_ff @(posedge aclk) begin
                if (en[k]) begin
                    n_reg[k]   <= n_reg[k-1];
                    d_reg[k]   <= d_reg[k-1];
                    rem_reg[k] <= rem_next;
                end
            end
        end
    end

    assign q   = q_reg[QW];
    assign ovf = ovf_reg[QW];

endmodule

[rtl/segment_intersection.sv]
// top level: pipelined two-segment crossing test with rounded intersection point
//
//  channel  | direction | tdata                                   | tuser
//  s_       | in        | ax, ay, bx, by_coord, cx, cy, dx, dy    | -
//  m_       | out       | cross_x, cross_y                        | status
//
//  one item per cycle while the output is not stalled; 6 arithmetic stages,
//  COORD_WIDTH + 2 divider stages and one output register
//  the divider, one quotient bit per stage, sets the depth
//  aresetn clears all stage valid bits; payload registers are not reset
//  each stage holds when it is full and the next one cannot take its item,
//  so bubbles close up and the input stays ready until every stage is full
`timescale 1ns / 1ps

module segment_intersection
    import segx_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // ax, ay, bx, by_coord, cx, cy, dx, dy
    input  logic [((8*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // cross_x, cross_y
    output logic [((2*COORD_WIDTH+7)/8)*8-1:0] m_tdata,
    // status
    output logic [STATUS_WIDTH-1:0] m_tuser
);

    localparam int W     = COORD_WIDTH;
    localparam int OUT_TW = ((2*W+7)/8)*8;
    localparam int AW    = W + 1;
    localparam int PW    = 2 * W;
    localparam int CW    = 2 * W + 1;
    localparam int MPW   = AW + W;
    localparam int DPW   = 2 * AW;
    localparam int SW    = 2 * W + 3;
    localparam int DETW  = 2 * W + 3;
    localparam int NPW   = AW + CW;
    localparam int NUMW  = NPW + 1;
    localparam int NW    = NUMW + 2;
    localparam int DW    = DETW + 1;
    localparam int QW    = W + 1;
    localparam int DIV0  = 6;
    localparam int NS    = DIV0 + QW + 2;

    typedef struct packed {
        status_t              status;
        logic signed [W-1:0]  x1;
        logic signed [W-1:0]  y1;
        logic                 negx;
        logic                 negy;
    } side_t;

    logic [NS-1:0] v_reg;
    logic [NS-1:0] en;

    always_comb begin
        en[NS-1] = !v_reg[NS-1] || m_tready;
        for (int i = NS - 2; i >= 0; i--) begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (en[0]) begin
                v_reg[0] <= s_tvalid;
            end
            for (int i = 1; i < NS; i++) begin
                if (en[i]) begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = v_reg[NS-1];

    // stage 0: line coefficients and endpoint cross products
    logic signed [W-1:0] i_x1, i_y1, i_x2, i_y2, i_x3, i_y3, i_x4, i_y4;

    assign i_x1 = s_tdata[0*W +: W];
    assign i_y1 = s_tdata[1*W +: W];
    assign i_x2 = s_tdata[2*W +: W];
    assign i_y2 = s_tdata[3*W +: W];
    assign i_x3 = s_tdata[4*W +: W];
    assign i_y3 = s_tdata[5*W +: W];
    assign i_x4 = s_tdata[6*W +: W];
    assign i_y4 = s_tdata[7*W +: W];

    logic signed [W-1:0]  s0_x1_reg, s0_y1_reg, s0_x2_reg, s0_y2_reg;
    logic signed [W-1:0]  s0_x3_reg, s0_y3_reg, s0_x4_reg, s0_y4_reg;
    logic signed [AW-1:0] s0_a1_reg, s0_b1_reg, s0_a2_reg, s0_b2_reg;
    logic signed [PW-1:0] s0_p21_reg, s0_p12_reg, s0_p43_reg, s0_p34_reg;

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            s0_x1_reg  <= i_x1;
            s0_y1_reg  <= i_y1;
            s0_x2_reg  <= i_x2;
            s0_y2_reg  <= i_y2;
            s0_x3_reg  <= i_x3;
            s0_y3_reg  <= i_y3;
            s0_x4_reg  <= i_x4;
            s0_y4_reg  <= i_y4;
            s0_a1_reg  <= $signed({i_y2[W-1], i_y2}) - $signed({i_y1[W-1], i_y1});
            s0_b1_reg  <= $signed({i_x1[W-1], i_x1}) - $signed({i_x2[W-1], i_x2});
            s0_a2_reg  <= $signed({i_y4[W-1], i_y4}) - $signed({i_y3[W-1], i_y3});
            s0_b2_reg  <= $signed({i_x3[W-1], i_x3}) - $signed({i_x4[W-1], i_x4});
            s0_p21_reg <= i_x2 * i_y1;
            s0_p12_reg <= i_x1 * i_y2;
            s0_p43_reg <= i_x4 * i_y3;
            s0_p34_reg <= i_x3 * i_y4;
        end
    end

    // stage 1: line offsets and side test products
    logic signed [W-1:0]   s1_x1_reg, s1_y1_reg;
    logic signed [AW-1:0]  s1_a1_reg, s1_b1_reg, s1_a2_reg, s1_b2_reg;
    logic signed [CW-1:0]  s1_c1_reg, s1_c2_reg;
    logic signed [MPW-1:0] s1_a1x3_reg, s1_b1y3_reg, s1_a1x4_reg, s1_b1y4_reg;
    logic signed [MPW-1:0] s1_a2x1_reg, s1_b2y1_reg, s1_a2x2_reg, s1_b2y2_reg;
    logic signed [DPW-1:0] s1_a1b2_reg, s1_a2b1_reg;

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            s1_x1_reg   <= s0_x1_reg;
            s1_y1_reg   <= s0_y1_reg;
            s1_a1_reg   <= s0_a1_reg;
            s1_b1_reg   <= s0_b1_reg;
            s1_a2_reg   <= s0_a2_reg;
            s1_b2_reg   <= s0_b2_reg;
            s1_c1_reg   <= CW'(s0_p21_reg) - CW'(s0_p12_reg);
            s1_c2_reg   <= CW'(s0_p43_reg) - CW'(s0_p34_reg);
            s1_a1x3_reg <= s0_a1_reg * s0_x3_reg;
            s1_b1y3_reg <= s0_b1_reg * s0_y3_reg;
            s1_a1x4_reg <= s0_a1_reg * s0_x4_reg;
            s1_b1y4_reg <= s0_b1_reg * s0_y4_reg;
            s1_a2x1_reg <= s0_a2_reg * s0_x1_reg;
            s1_b2y1_reg <= s0_b2_reg * s0_y1_reg;
            s1_a2x2_reg <= s0_a2_reg * s0_x2_reg;
            s1_b2y2_reg <= s0_b2_reg * s0_y2_reg;
            s1_a1b2_reg <= s0_a1_reg * s0_b2_reg;
            s1_a2b1_reg <= s0_a2_reg * s0_b1_reg;
        end
    end

    // stage 2: side tests, determinant, numerator products
    logic signed [W-1:0]    s2_x1_reg, s2_y1_reg;
    logic signed [SW-1:0]   s2_s1_reg, s2_s2_reg, s2_s3_reg, s2_s4_reg;
    logic signed [DETW-1:0] s2_det_reg;
    logic signed [NPW-1:0]  s2_m1_reg, s2_m2_reg, s2_m3_reg, s2_m4_reg;

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            s2_x1_reg  <= s1_x1_reg;
            s2_y1_reg  <= s1_y1_reg;
            s2_s3_reg  <= SW'(s1_a1x3_reg) + SW'(s1_b1y3_reg) + SW'(s1_c1_reg);
            s2_s4_reg  <= SW'(s1_a1x4_reg) + SW'(s1_b1y4_reg) + SW'(s1_c1_reg);
            s2_s1_reg  <= SW'(s1_a2x1_reg) + SW'(s1_b2y1_reg) + SW'(s1_c2_reg);
            s2_s2_reg  <= SW'(s1_a2x2_reg) + SW'(s1_b2y2_reg) + SW'(s1_c2_reg);
            s2_det_reg <= DETW'(s1_a1b2_reg) - DETW'(s1_a2b1_reg);
            s2_m1_reg  <= s1_b1_reg * s1_c2_reg;
            s2_m2_reg  <= s1_b2_reg * s1_c1_reg;
            s2_m3_reg  <= s1_a2_reg * s1_c1_reg;
            s2_m4_reg  <= s1_a1_reg * s1_c2_reg;
        end
    end

    // stage 3: status and numerators
    logic    rej_ab, rej_cd;
    status_t status_next;

    assign rej_ab = (|s2_s3_reg && |s2_s4_reg && (s2_s3_reg[SW-1] == s2_s4_reg[SW-1]));
    assign rej_cd = (|s2_s1_reg && |s2_s2_reg && (s2_s1_reg[SW-1] == s2_s2_reg[SW-1]));

    always_comb begin
        if (rej_ab || rej_cd) begin
            status_next = ST_NONE;
        end else if (s2_det_reg == '0) begin
            status_next = ST_PARALLEL;
        end else begin
            status_next = ST_CROSS;
        end
    end

    status_t                s3_status_reg;
    logic signed [W-1:0]    s3_x1_reg, s3_y1_reg;
    logic signed [DETW-1:0] s3_det_reg;
    logic signed [NUMW-1:0] s3_numx_reg, s3_numy_reg;

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            s3_status_reg <= status_next;
            s3_x1_reg     <= s2_x1_reg;
            s3_y1_reg     <= s2_y1_reg;
            s3_det_reg    <= s2_det_reg;
            s3_numx_reg   <= NUMW'(s2_m1_reg) - NUMW'(s2_m2_reg);
            s3_numy_reg   <= NUMW'(s2_m3_reg) - NUMW'(s2_m4_reg);
        end
    end

    // stage 4: magnitudes and quotient signs
    side_t           s4_side_reg;
    logic [NUMW-1:0] s4_anx_reg, s4_any_reg;
    logic [DETW-1:0] s4_ad_reg;

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            s4_side_reg.status <= s3_status_reg;
            s4_side_reg.x1     <= s3_x1_reg;
            s4_side_reg.y1     <= s3_y1_reg;
            s4_side_reg.negx   <= s3_numx_reg[NUMW-1] != s3_det_reg[DETW-1];
            s4_side_reg.negy   <= s3_numy_reg[NUMW-1] != s3_det_reg[DETW-1];
            s4_anx_reg <= s3_numx_reg[NUMW-1] ? NUMW'(-s3_numx_reg) : NUMW'(s3_numx_reg);
            s4_any_reg <= s3_numy_reg[NUMW-1] ? NUMW'(-s3_numy_reg) : NUMW'(s3_numy_reg);
            s4_ad_reg  <= s3_det_reg[DETW-1] ? DETW'(-s3_det_reg) : DETW'(s3_det_reg);
        end
    end

    // stage 5: half offset for round to nearest
    side_t         s5_side_reg;
    logic [NW-1:0] s5_nx_reg, s5_ny_reg;
    logic [DW-1:0] s5_d_reg;

    always_ff @(posedge aclk) begin
        if (en[5]) begin
            s5_side_reg <= s4_side_reg;
            s5_nx_reg   <= {s4_anx_reg, 1'b0} + NW'(s4_ad_reg);
            s5_ny_reg   <= {s4_any_reg, 1'b0} + NW'(s4_ad_reg);
            s5_d_reg    <= {s4_ad_reg, 1'b0};
        end
    end

    // divider stages
    logic [QW-1:0] qx, qy;
    logic          ovfx, ovfy;

    segx_div #(.QW(QW), .NW(NW), .DW(DW)) u_div_x (
        .aclk (aclk),
        .en   (en[DIV0 +: QW+1]),
        .n    (s5_nx_reg),
        .d    (s5_d_reg),
        .q    (qx),
        .ovf  (ovfx)
    );

    segx_div #(.QW(QW), .NW(NW), .DW(DW)) u_div_y (
        .aclk (aclk),
        .en   (en[DIV0 +: QW+1]),
        .n    (s5_ny_reg),
        .d    (s5_d_reg),
        .q    (qy),
        .ovf  (ovfy)
    );

    side_t side_reg [0:QW];

    always_ff @(posedge aclk) begin
        if (en[DIV0]) begin
            side_reg[0] <= s5_side_reg;
        end
        for (int k = 1; k <= QW; k++) begin
            if (en[DIV0 + k]) begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // output stage: clamp, sign, select by status
    localparam logic [QW-1:0] LIM   = QW'(1) << (W - 1);
    localparam logic [QW-1:0] LIMM1 = LIM - QW'(1);

    function automatic logic [W-1:0] sat_coord(input logic [QW-1:0] q, input logic ovf,
                                               input logic neg);
        logic [W-1:0] r;
        if (neg) begin
            r = (ovf || q > LIM) ? W'(0 - LIM) : W'(0 - q);
        end else begin
            r = (ovf || q > LIMM1) ? W'(LIMM1) : W'(q);
        end
        return r;
    endfunction

    side_t        sd;
    logic [W-1:0] cx_next, cy_next;

    assign sd = side_reg[QW];

    always_comb begin
        case (sd.status)
            ST_CROSS: begin
                cx_next = sat_coord(qx, ovfx, sd.negx);
                cy_next = sat_coord(qy, ovfy, sd.negy);
            end
            ST_PARALLEL: begin
                cx_next = sd.x1;
                cy_next = sd.y1;
            end
            default: begin
                cx_next = '0;
                cy_next = '0;
            end
        endcase
    end

    status_t      out_status_reg;
    logic [W-1:0] out_x_reg, out_y_reg;

    always_ff @(posedge aclk) begin
        if (en[NS-1]) begin
            out_status_reg <= sd.status;
            out_x_reg      <= cx_next;
            out_y_reg      <= cy_next;
        end
    end

    assign m_tuser = out_status_reg;
    assign m_tdata = OUT_TW'({out_y_reg, out_x_reg});

    a_idle_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input not ready with an empty output stage");

    a_none_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == ST_NONE) |-> (out_x_reg == '0 && out_y_reg == '0))
        else $error("point not zero for a rejected pair");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == ST_NONE || m_tuser == ST_CROSS || m_tuser == ST_PARALLEL))
        else $error("undefined status code");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

endmodule
